### rtl/core/lpi_pkg.sv
// Shared types and constants for the link pairing indicator controller.
package lpi_pkg;

  localparam int unsigned BlinkWidth = 4;
  localparam int unsigned PairWidth  = 12;
  localparam int unsigned CfgWidth   = 12;

  localparam logic [BlinkWidth-1:0] BlinkPeriodReset    = 4'd5;
  localparam logic [PairWidth-1:0]  PairingTimeoutReset = 12'd1200;

  typedef enum logic [1:0] {
    MODE_OFF          = 2'd0,
    MODE_PAIRING      = 2'd1,
    MODE_CONNECTED    = 2'd2,
    MODE_RECONNECTING = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_PAIR      = 3'd1,
    CMD_POWER_OFF = 3'd2,
    CMD_TOGGLE    = 3'd3,
    CMD_LINK      = 3'd4,
    CMD_SHUTDOWN  = 3'd5
  } cmd_code_t;

  typedef enum logic {
    CFG_BLINK_PERIOD    = 1'b0,
    CFG_PAIRING_TIMEOUT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [2:0] command;
    logic       connected;
  } cmd_t;

  typedef struct packed {
    logic [1:0] link_state;
    logic       icon_on;
    logic       radio_power;
  } status_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  icon;
    logic                  pair_pending;
    logic                  off_pending;
    logic                  link_latched;
    logic                  radio_en;
    logic [BlinkWidth-1:0] blink_count;
    logic [PairWidth-1:0]  pair_count;
  } lpi_state_t;

  localparam lpi_state_t StateReset = '{
    mode:         MODE_OFF,
    icon:         1'b0,
    pair_pending: 1'b0,
    off_pending:  1'b0,
    link_latched: 1'b0,
    radio_en:     1'b0,
    blink_count:  '0,
    pair_count:   '0
  };

endpackage

### rtl/core/lpi_step.sv
// Next-state logic of the link pairing indicator for one request.
module lpi_step (
  input  lpi_pkg::lpi_state_t               cur,
  input  lpi_pkg::cmd_t                     cmd,
  input  logic [lpi_pkg::BlinkWidth-1:0]    blink_period,
  input  logic [lpi_pkg::PairWidth-1:0]     pairing_timeout,
  output lpi_pkg::lpi_state_t               nxt
);

  lpi_pkg::lpi_state_t s;
  logic [lpi_pkg::BlinkWidth:0] blink_inc;
  logic [lpi_pkg::PairWidth:0]  pair_inc;
  logic [lpi_pkg::PairWidth-1:0] pair_sat;

  always_comb begin
    s         = cur;
    blink_inc = '0;
    pair_inc  = '0;
    pair_sat  = '0;
    unique case (lpi_pkg::cmd_code_t'(cmd.command))
      lpi_pkg::CMD_TICK: begin
        if (s.off_pending) begin
          s.mode         = lpi_pkg::MODE_OFF;
          s.icon         = 1'b0;
          s.blink_count  = '0;
          s.pair_count   = '0;
          s.off_pending  = 1'b0;
          s.pair_pending = 1'b0;
          s.link_latched = 1'b0;
        end
        if (s.pair_pending) begin
          s.mode         = lpi_pkg::MODE_PAIRING;
          s.pair_count   = '0;
          s.blink_count  = '0;
          s.icon         = 1'b1;
          s.pair_pending = 1'b0;
          s.radio_en     = 1'b1;
        end
        // Mode transitions on the latched link level.
        if (s.mode == lpi_pkg::MODE_PAIRING || s.mode == lpi_pkg::MODE_RECONNECTING) begin
          s.radio_en = 1'b1;
          if (s.link_latched) begin
            s.mode        = lpi_pkg::MODE_CONNECTED;
            s.icon        = 1'b1;
            s.blink_count = '0;
          end
        end else if (s.mode == lpi_pkg::MODE_CONNECTED) begin
          if (!s.link_latched) begin
            s.mode        = lpi_pkg::MODE_RECONNECTING;
            s.blink_count = '0;
          end
        end else begin
          s.radio_en = 1'b0;
        end
        // Icon blink.
        if (s.mode == lpi_pkg::MODE_PAIRING || s.mode == lpi_pkg::MODE_RECONNECTING) begin
          blink_inc = {1'b0, s.blink_count} + 1'b1;
          if (blink_inc >= {1'b0, blink_period}) begin
            s.blink_count = '0;
            s.icon        = ~s.icon;
          end else begin
            s.blink_count = blink_inc[lpi_pkg::BlinkWidth-1:0];
          end
        end else if (s.mode == lpi_pkg::MODE_CONNECTED) begin
          s.icon = 1'b1;
        end else begin
          s.icon = 1'b0;
        end
        // Pairing timeout; the count saturates at its full scale.
        if (s.mode == lpi_pkg::MODE_PAIRING) begin
          pair_inc = {1'b0, s.pair_count} + 1'b1;
          pair_sat = pair_inc[lpi_pkg::PairWidth] ? '1 : pair_inc[lpi_pkg::PairWidth-1:0];
          s.pair_count = pair_sat;
          if (pair_sat >= pairing_timeout) begin
            s.mode         = lpi_pkg::MODE_OFF;
            s.icon         = 1'b0;
            s.link_latched = 1'b0;
          end
        end
      end
      lpi_pkg::CMD_PAIR: begin
        s.pair_pending = 1'b1;
        s.radio_en     = 1'b1;
      end
      lpi_pkg::CMD_POWER_OFF: begin
        s.off_pending = 1'b1;
        s.radio_en    = 1'b0;
      end
      lpi_pkg::CMD_TOGGLE: begin
        if (s.mode == lpi_pkg::MODE_OFF && !s.radio_en) begin
          s.pair_pending = 1'b1;
          s.radio_en     = 1'b1;
        end else if (s.mode != lpi_pkg::MODE_CONNECTED) begin
          s.off_pending = 1'b1;
          s.radio_en    = 1'b0;
        end
      end
      lpi_pkg::CMD_LINK: begin
        s.link_latched = cmd.connected;
      end
      lpi_pkg::CMD_SHUTDOWN: begin
        s.mode     = lpi_pkg::MODE_OFF;
        s.icon     = 1'b0;
        s.radio_en = 1'b0;
      end
      default: begin
      end
    endcase
    nxt = s;
  end

endmodule

### rtl/core/link_pairing_indicator_fsm_unit.sv
// Top level of the link pairing indicator controller.
//
// Requests arrive on the cmd channel (cmd_valid, cmd_stall, cmd), each
// carrying one event: a tick, a pair, power-off or toggle request, a link
// level update or a shutdown. Every request produces exactly one status
// item on the status channel (status_valid, status_stall, status) holding
// the link mode, the icon level and the radio power enable after the event.
// A request is accepted on a clock edge where cmd_valid is high and
// cmd_stall is low; the status appears in the next cycle from the output
// register, so one request can be taken in every cycle while the receiver
// does not stall, as the controller state is updated for every request.
// When the receiver stalls, the held status stays put and cmd_stall rises
// in the same cycle, so no request is taken until the status is drained;
// a status that is taken frees room for the next request in that cycle.
// The user must write the registers (blink period, pairing timeout) via cfg
// only while the block is idle; the block does not enforce it. Synchronous
// reset returns the mode to off, clears the pending requests, counters and
// latched link level, restores the defaults and empties the output register.
module link_pairing_indicator_fsm_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  lpi_pkg::cmd_t                 cmd,
  output logic                          status_valid,
  input  logic                          status_stall,
  output lpi_pkg::status_t              status,
  input  logic                          cfg_write_enable,
  input  logic                          cfg_index,
  input  logic [lpi_pkg::CfgWidth-1:0]  cfg_data
);

  lpi_pkg::lpi_state_t              state;
  lpi_pkg::lpi_state_t              state_next;
  logic [lpi_pkg::BlinkWidth-1:0]   blink_period;
  logic [lpi_pkg::PairWidth-1:0]    pairing_timeout;
  logic                             accept;

  // The output register may be refilled when empty or while being drained.
  assign cmd_stall = status_valid & status_stall;
  assign accept    = cmd_valid & ~cmd_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period    <= lpi_pkg::BlinkPeriodReset;
      pairing_timeout <= lpi_pkg::PairingTimeoutReset;
    end else if (cfg_write_enable) begin
      unique case (lpi_pkg::cfg_index_t'(cfg_index))
        lpi_pkg::CFG_BLINK_PERIOD:    blink_period    <= cfg_data[lpi_pkg::BlinkWidth-1:0];
        lpi_pkg::CFG_PAIRING_TIMEOUT: pairing_timeout <= cfg_data[lpi_pkg::PairWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  lpi_step u_step (
    .cur             (state),
    .cmd             (cmd),
    .blink_period    (blink_period),
    .pairing_timeout (pairing_timeout),
    .nxt             (state_next)
  );

  // Controller state advances once for each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpi_pkg::StateReset;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Output register: valid is control, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (accept) begin
      status_valid <= 1'b1;
    end else if (!status_stall) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status.link_state  <= state_next.mode;
      status.icon_on     <= state_next.icon;
      status.radio_power <= state_next.radio_en;
    end
  end

endmodule

### bench/link_pairing_indicator_fsm_unit_tb.sv
// Self-checking testbench for the link pairing indicator controller.
`timescale 1ns / 1ps

module link_pairing_indicator_fsm_unit_tb;

  // Command codes six and seven have no meaning. The block must report its
  // current status for them and change nothing.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int DirectedCount = 25;
  localparam int PhaseCount    = 5;
  localparam int PressurePhase = 4;
  localparam int HoldOffCycles = 120;
  localparam int RunLimit      = 200000;
  localparam int ReportLimit   = 10;

  localparam lpi_pkg::status_t StatusOffIdle    = '{lpi_pkg::MODE_OFF, 1'b0, 1'b0};
  localparam lpi_pkg::status_t StatusOffPowered = '{lpi_pkg::MODE_OFF, 1'b0, 1'b1};
  localparam lpi_pkg::status_t NoStatus         = '0;

  typedef struct packed {
    lpi_pkg::cmd_t    req;
    logic             typed;
    lpi_pkg::status_t want;
  } directed_row_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cmd_valid;
  logic                         cmd_stall;
  lpi_pkg::cmd_t                cmd;
  logic                         status_valid;
  logic                         status_stall;
  lpi_pkg::status_t             status;
  logic                         cfg_write_enable;
  logic                         cfg_index;
  logic [lpi_pkg::CfgWidth-1:0] cfg_data;

  // Statuses that the block owes us, oldest first.
  lpi_pkg::status_t awaited_status [$];
  int      status_faults = 0;
  int      cycle_count = 0;
  int      hold_off_until = 0;
  int      sender_idle_pct = 0;
  int      stall_pct = 0;

  // Our own copy of the controller state and of its two registers.
  lpi_pkg::mode_t                 link_mode;
  logic                           icon_lit;
  logic                           pair_held;
  logic                           off_held;
  logic                           link_seen;
  logic                           radio_on;
  logic [lpi_pkg::BlinkWidth-1:0] blink_count;
  logic [lpi_pkg::PairWidth-1:0]  pair_count;
  logic [lpi_pkg::BlinkWidth-1:0] blink_period_set;
  logic [lpi_pkg::PairWidth-1:0]  pair_limit_set;

  // The directed walk starts from reset with the register defaults. The
  // status is typed in only where it is plain to see; the other rows go
  // through the predictor.
  directed_row_t directed_rows [DirectedCount] = '{
    '{'{lpi_pkg::CMD_TICK,      1'b0}, 1'b1, StatusOffIdle},
    '{'{CMD_SPARE_7,            1'b1}, 1'b1, StatusOffIdle},
    '{'{CMD_SPARE_6,            1'b0}, 1'b1, StatusOffIdle},
    '{'{lpi_pkg::CMD_LINK,      1'b1}, 1'b1, StatusOffIdle},
    '{'{lpi_pkg::CMD_PAIR,      1'b0}, 1'b1, StatusOffPowered},
    '{'{lpi_pkg::CMD_TICK,      1'b0}, 1'b0, NoStatus},
    '{'{lpi_pkg::CMD_TOGGLE,    1'b0}, 1'b0, NoStatus},
    '{'{lpi_pkg::CMD_LINK,      1'b0}, 1'b0, NoStatus},
    '{'{lpi_pkg::CMD_TICK,      1'b0}, 1'b0, NoStatus},
    '{'{lpi_pkg::CMD_TICK,      1'b1}, 1'b0, NoStatus},
    '{'{lpi_pkg::CMD_TICK,      1'b0}, 1'b0, NoStatus},
    '{'{lpi_pkg::CMD_TICK,      1'b0}, 1'b0, NoStatus},
    '{'{lpi_pkg::CMD_TICK,      1'b0}, 1'b0, NoStatus},
    '{'{lpi_pkg::CMD_TICK,      1'b0}, 1'b0, NoStatus},
    '{'{lpi_pkg::CMD_TOGGLE,    1'b1}, 1'b0, NoStatus},
    '{'{lpi_pkg::CMD_TICK,      1'b0}, 1'b1, StatusOffIdle},
    '{'{lpi_pkg::CMD_TOGGLE,    1'b0}, 1'b1, StatusOffPowered},
    '{'{lpi_pkg::CMD_POWER_OFF, 1'b1}, 1'b1, StatusOffIdle},
    '{'{lpi_pkg::CMD_TICK,      1'b0}, 1'b1, StatusOffIdle},
    '{'{lpi_pkg::CMD_PAIR,      1'b1}, 1'b1, StatusOffPowered},
    '{'{lpi_pkg::CMD_SHUTDOWN,  1'b0}, 1'b1, StatusOffIdle},
    '{'{lpi_pkg::CMD_TICK,      1'b0}, 1'b0, NoStatus},
    '{'{lpi_pkg::CMD_LINK,      1'b1}, 1'b0, NoStatus},
    '{'{lpi_pkg::CMD_TICK,      1'b1}, 1'b0, NoStatus},
    '{'{lpi_pkg::CMD_SHUTDOWN,  1'b1}, 1'b1, StatusOffIdle}
  };

  link_pairing_indicator_fsm_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (cmd_valid),
    .cmd_stall        (cmd_stall),
    .cmd              (cmd),
    .status_valid     (status_valid),
    .status_stall     (status_stall),
    .status           (status),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Applies one request to our copy of the controller and returns the status
  // that the block should report for it.
  function automatic lpi_pkg::status_t advance_link_status(input lpi_pkg::cmd_t req);
    logic [lpi_pkg::BlinkWidth:0] blink_next;
    logic [lpi_pkg::PairWidth:0]  pair_next;
    lpi_pkg::status_t             result;
    case (req.command)
      lpi_pkg::CMD_TICK: begin
        // A pending power-off wins over everything and drops both requests.
        if (off_held) begin
          link_mode   = lpi_pkg::MODE_OFF;
          icon_lit    = 1'b0;
          blink_count = '0;
          pair_count  = '0;
          off_held    = 1'b0;
          pair_held   = 1'b0;
          link_seen   = 1'b0;
        end
        if (pair_held) begin
          link_mode   = lpi_pkg::MODE_PAIRING;
          pair_count  = '0;
          blink_count = '0;
          icon_lit    = 1'b1;
          pair_held   = 1'b0;
          radio_on    = 1'b1;
        end
        // Mode changes driven by the latched link level.
        if (link_mode == lpi_pkg::MODE_PAIRING || link_mode == lpi_pkg::MODE_RECONNECTING) begin
          radio_on = 1'b1;
          if (link_seen) begin
            link_mode   = lpi_pkg::MODE_CONNECTED;
            icon_lit    = 1'b1;
            blink_count = '0;
          end
        end else if (link_mode == lpi_pkg::MODE_CONNECTED) begin
          if (!link_seen) begin
            link_mode   = lpi_pkg::MODE_RECONNECTING;
            blink_count = '0;
          end
        end else begin
          radio_on = 1'b0;
        end
        // Blinking: the counter is one bit wider so that the wrap compare
        // is never cut short.
        if (link_mode == lpi_pkg::MODE_PAIRING || link_mode == lpi_pkg::MODE_RECONNECTING) begin
          blink_next = {1'b0, blink_count} + 1'b1;
          if (blink_next >= {1'b0, blink_period_set}) begin
            blink_next = '0;
            icon_lit   = ~icon_lit;
          end
          blink_count = blink_next[lpi_pkg::BlinkWidth-1:0];
        end else if (link_mode == lpi_pkg::MODE_CONNECTED) begin
          icon_lit = 1'b1;
        end else begin
          icon_lit = 1'b0;
        end
        // Pairing timeout; the count saturates and is left where it stopped.
        if (link_mode == lpi_pkg::MODE_PAIRING) begin
          pair_next = {1'b0, pair_count} + 1'b1;
          if (pair_next > {1'b0, {lpi_pkg::PairWidth{1'b1}}}) begin
            pair_next = {1'b0, {lpi_pkg::PairWidth{1'b1}}};
          end
          pair_count = pair_next[lpi_pkg::PairWidth-1:0];
          if (pair_next >= {1'b0, pair_limit_set}) begin
            link_mode = lpi_pkg::MODE_OFF;
            icon_lit  = 1'b0;
            link_seen = 1'b0;
          end
        end
      end
      lpi_pkg::CMD_PAIR: begin
        pair_held = 1'b1;
        radio_on  = 1'b1;
      end
      lpi_pkg::CMD_POWER_OFF: begin
        off_held = 1'b1;
        radio_on = 1'b0;
      end
      lpi_pkg::CMD_TOGGLE: begin
        // Off and unpowered means pair; connected ignores the toggle.
        if (link_mode == lpi_pkg::MODE_OFF && !radio_on) begin
          pair_held = 1'b1;
          radio_on  = 1'b1;
        end else if (link_mode != lpi_pkg::MODE_CONNECTED) begin
          off_held = 1'b1;
          radio_on = 1'b0;
        end
      end
      lpi_pkg::CMD_LINK: begin
        link_seen = req.connected;
      end
      lpi_pkg::CMD_SHUTDOWN: begin
        // Pending requests survive a shutdown.
        link_mode = lpi_pkg::MODE_OFF;
        icon_lit  = 1'b0;
        radio_on  = 1'b0;
      end
      default: begin
      end
    endcase
    result.link_state  = link_mode;
    result.icon_on     = icon_lit;
    result.radio_power = radio_on;
    return result;
  endfunction

  // Random requests are weighted towards ticks and link updates so that the
  // controller spends its time pairing, connecting and losing the link.
  function automatic lpi_pkg::cmd_t random_request();
    int            pick;
    lpi_pkg::cmd_t req;
    pick = $urandom_range(99);
    req.connected = 1'($urandom_range(1));
    if (pick < 42) begin
      req.command = lpi_pkg::CMD_TICK;
    end else if (pick < 50) begin
      req.command = lpi_pkg::CMD_PAIR;
    end else if (pick < 55) begin
      req.command = lpi_pkg::CMD_POWER_OFF;
    end else if (pick < 63) begin
      req.command = lpi_pkg::CMD_TOGGLE;
    end else if (pick < 85) begin
      req.command = lpi_pkg::CMD_LINK;
    end else if (pick < 90) begin
      req.command = lpi_pkg::CMD_SHUTDOWN;
    end else if (pick < 97) begin
      req.command = lpi_pkg::CMD_TICK;
    end else begin
      req.command = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
    end
    return req;
  endfunction

  // Offers one request, holding it steady until the block takes it, and
  // records the status owed for it. A typed status overrides the predictor
  // but the predictor still moves on.
  task automatic push_request(input lpi_pkg::cmd_t req, input logic typed,
                              input lpi_pkg::status_t typed_want);
    lpi_pkg::status_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= req;
    @(posedge clk);
    while (cmd_stall) begin
      @(posedge clk);
    end
    predicted = advance_link_status(req);
    awaited_status.push_back(typed ? typed_want : predicted);
  endtask

  // Writes both registers one after the other. The blink period write
  // carries random junk above its four bits, which the block must drop.
  task automatic write_settings(input logic [lpi_pkg::BlinkWidth-1:0] blink,
                                input logic [lpi_pkg::PairWidth-1:0] pair_limit);
    cfg_write_enable <= 1'b1;
    cfg_index        <= lpi_pkg::CFG_BLINK_PERIOD;
    cfg_data         <= {8'($urandom_range(255)), blink};
    @(posedge clk);
    cfg_index        <= lpi_pkg::CFG_PAIRING_TIMEOUT;
    cfg_data         <= pair_limit;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    blink_period_set = blink;
    pair_limit_set   = pair_limit;
  endtask

  task automatic report_fault(input string what, input lpi_pkg::status_t want,
                              input lpi_pkg::status_t got);
    status_faults++;
    if (status_faults <= ReportLimit) begin
      $display("%0t: %s: expected mode %0d icon %0d radio %0d, got mode %0d icon %0d radio %0d",
               $time, what, want.link_state, want.icon_on, want.radio_power,
               got.link_state, got.icon_on, got.radio_power);
    end
  endtask

  // The run is bounded by a plain cycle count; it also times the long
  // receiver hold-off.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RunLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver stalls at the rate of the current phase, and stalls solidly
  // during a hold-off so that the output register fills and backs up the
  // request side.
  always @(posedge clk) begin
    if (cycle_count < hold_off_until) begin
      status_stall <= 1'b1;
    end else begin
      status_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every status taken is matched against the oldest one owed.
  always @(posedge clk) begin : status_check
    lpi_pkg::status_t want;
    if (!rst && status_valid && !status_stall) begin
      if (awaited_status.size() == 0) begin
        report_fault("status with no request behind it", NoStatus, status);
      end else begin
        want = awaited_status.pop_front();
        if (status.link_state !== want.link_state || status.icon_on !== want.icon_on ||
            status.radio_power !== want.radio_power) begin
          report_fault("status mismatch", want, status);
        end
      end
    end
  end

  initial begin : stimulus
    int            phase;
    int            sent;
    int            quota;
    lpi_pkg::cmd_t req;
    rst              <= 1'b1;
    cmd_valid        <= 1'b0;
    cmd              <= '0;
    cfg_write_enable <= 1'b0;
    cfg_index        <= lpi_pkg::CFG_BLINK_PERIOD;
    cfg_data         <= '0;
    link_mode        = lpi_pkg::MODE_OFF;
    icon_lit         = 1'b0;
    pair_held        = 1'b0;
    off_held         = 1'b0;
    link_seen        = 1'b0;
    radio_on         = 1'b0;
    blink_count      = '0;
    pair_count       = '0;
    blink_period_set = lpi_pkg::BlinkPeriodReset;
    pair_limit_set   = lpi_pkg::PairingTimeoutReset;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed walk with the reset defaults: every command, both link levels,
    // the unused codes, a full blink cycle while reconnecting, toggles while
    // connected, reconnecting and off, and requests that survive a shutdown.
    for (int i = 0; i < DirectedCount; i++) begin
      push_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases. Each begins once the block has drained, so the register
    // writes always land on an idle controller.
    for (phase = 0; phase < PhaseCount; phase++) begin
      cmd_valid <= 1'b0;
      while (awaited_status.size() != 0) begin
        @(posedge clk);
      end
      case (phase)
        0: begin
          // Zero period blinks on every tick; zero timeout ends pairing at once.
          write_settings('0, '0);
          sender_idle_pct = 0;
          stall_pct       = 0;
          quota           = 50;
        end
        1: begin
          write_settings('1, '1);
          sender_idle_pct = 58;
          stall_pct       = 0;
          quota           = 80;
        end
        2: begin
          write_settings(4'd1, 12'd1);
          sender_idle_pct = 0;
          stall_pct       = 58;
          quota           = 80;
        end
        3: begin
          write_settings(4'd3, 12'd25);
          sender_idle_pct = 37;
          stall_pct       = 37;
          quota           = 80;
        end
        default: begin
          write_settings(4'($urandom_range(14, 2)), 12'($urandom_range(60, 4)));
          sender_idle_pct = 0;
          stall_pct       = 0;
          quota           = 100;
        end
      endcase
      if (phase == PressurePhase) begin
        hold_off_until = cycle_count + HoldOffCycles;
      end
      sent = 0;
      while (sent < quota) begin
        req = random_request();
        push_request(req, 1'b0, NoStatus);
        if (req.command <= lpi_pkg::CMD_SHUTDOWN) begin
          sent++;
        end
      end
    end

    cmd_valid <= 1'b0;
    while (awaited_status.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (status_faults == 0 && awaited_status.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
